[rtl/ristab_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ristab_pkg
// Shared codes and types for the reference-counted inode slot table.
// ----------------------------------------------------------------------------
package ristab_pkg;

  // operation codes on the input channel
  localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // write enables towards the slot memories
  typedef struct packed {
    logic refs_we;
    logic tag_we;
  } ram_we_t;

endpackage : ristab_pkg
`default_nettype wire

[rtl/ristab_slot_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ristab_slot_ram
// Tag and count memories of the slot table: one write and one registered
// read port, sharing a read address.
// ----------------------------------------------------------------------------
module ristab_slot_ram #(
  parameter int SLOTS = 64,
  parameter int AW    = 6,
  parameter int IW    = 16,
  parameter int CW    = 16
) (
  input  wire                   clk,
  input  ristab_pkg::ram_we_t   we,
  input  wire  [AW-1:0]         wr_addr,
  input  wire  [IW-1:0]         wr_tag,
  input  wire  [CW-1:0]         wr_refs,
  input  wire  [AW-1:0]         rd_addr,
  output logic [IW-1:0]         rd_tag,
  output logic [CW-1:0]         rd_refs
);

  logic [IW-1:0] tag_mem  [SLOTS];
  logic [CW-1:0] refs_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (we.refs_we) begin
      refs_mem[wr_addr] <= wr_refs;
    end
    rd_tag  <= tag_mem[rd_addr];
    rd_refs <= refs_mem[rd_addr];
  end

endmodule : ristab_slot_ram
`default_nettype wire

[rtl/refcounted_inode_slot_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_inode_slot_table_unit
// Table of inode slots with reference counts: acquire by inode number,
// release by slot, clear all counts.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one item: func, inode_number
//   and slot_index. Every item gives exactly one result item on the output
//   channel (out_valid / out_stall). One item is worked on at a time.
//   An acquire scans the count and tag memories one slot per cycle; a hit
//   stops the scan early. A release reads one slot. A clear sweeps every
//   count to zero. Other codes go straight to their result.
//   After reset the block sweeps the count memory and holds in_stall high
//   meanwhile. The result sits in an output register; the next item is taken
//   while it waits. If the receiver stalls, a finished item holds its result
//   and the table update until the output register frees.
// ----------------------------------------------------------------------------
module refcounted_inode_slot_table_unit #(
  parameter int SLOTS      = 64,
  parameter int INODE_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_func,
  input  wire  [15:0] in_inode_number,
  input  wire  [5:0]  in_slot_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic        out_load_needed,
  output logic        out_writeback_needed,
  output logic [15:0] out_inode_out
);

  localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW  = INODE_BITS;
  localparam int CW  = COUNT_BITS;
  localparam int INW = (INODE_BITS < 16) ? INODE_BITS : 16;
  localparam logic [AW-1:0] LAST     = AW'(SLOTS - 1);
  localparam logic [CW-1:0] COUNT_TOP = {CW{1'b1}};

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          clr_rep_r, clr_rep_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [IW-1:0] ino_r, ino_nxt;
  logic          have_free_r, have_free_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [5:0]    idx_r, idx_nxt;

  logic [1:0]    res_status_r, res_status_nxt;
  logic [5:0]    res_slot_r, res_slot_nxt;
  logic          res_load_r, res_load_nxt;
  logic          res_wb_r, res_wb_nxt;
  logic [15:0]   res_inode_r, res_inode_nxt;

  ristab_pkg::ram_we_t pend_we_r, pend_we_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [IW-1:0] pend_tag_r, pend_tag_nxt;
  logic [CW-1:0] pend_refs_r, pend_refs_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [5:0]    out_slot_r, out_slot_nxt;
  logic          out_load_r, out_load_nxt;
  logic          out_wb_r, out_wb_nxt;
  logic [15:0]   out_inode_r, out_inode_nxt;

  ristab_pkg::ram_we_t ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [IW-1:0] ram_wr_tag;
  logic [CW-1:0] ram_wr_refs;
  logic [AW-1:0] ram_rd_addr;
  logic [IW-1:0] ram_rd_tag;
  logic [CW-1:0] ram_rd_refs;

  logic [IW-1:0] ino_in;
  logic          in_accept;
  logic          out_free;
  logic          hit;
  logic          last_free;
  logic [CW-1:0] dec_refs;

  assign ino_in    = IW'(in_inode_number[INW-1:0]);
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = (ram_rd_refs != '0) && (ram_rd_tag == ino_r);
  assign last_free = have_free_r || (ram_rd_refs == '0);
  assign dec_refs  = ram_rd_refs - CW'(1);

  ristab_slot_ram #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .IW    (IW),
    .CW    (CW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_tag  (ram_wr_tag),
    .wr_refs (ram_wr_refs),
    .rd_addr (ram_rd_addr),
    .rd_tag  (ram_rd_tag),
    .rd_refs (ram_rd_refs)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    clr_rep_nxt    = clr_rep_r;
    pidx_nxt       = pidx_r;
    ino_nxt        = ino_r;
    have_free_nxt  = have_free_r;
    free_nxt       = free_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_load_nxt   = res_load_r;
    res_wb_nxt     = res_wb_r;
    res_inode_nxt  = res_inode_r;
    pend_we_nxt    = pend_we_r;
    pend_addr_nxt  = pend_addr_r;
    pend_tag_nxt   = pend_tag_r;
    pend_refs_nxt  = pend_refs_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_load_nxt   = out_load_r;
    out_wb_nxt     = out_wb_r;
    out_inode_nxt  = out_inode_r;
    ram_we         = '0;
    ram_wr_addr    = pend_addr_r;
    ram_wr_tag     = pend_tag_r;
    ram_wr_refs    = pend_refs_r;
    ram_rd_addr    = '0;

    case (state_r)
      S_INIT: begin
        // zero one count per cycle
        ram_we.refs_we = 1'b1;
        ram_wr_addr    = cnt_r;
        ram_wr_refs    = '0;
        cnt_nxt        = AW'(cnt_r + 1'b1);
        if (cnt_r == LAST) begin
          cnt_nxt     = '0;
          clr_rep_nxt = 1'b0;
          state_nxt   = clr_rep_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = ristab_pkg::ST_OK;
          res_slot_nxt   = '0;
          res_load_nxt   = 1'b0;
          res_wb_nxt     = 1'b0;
          res_inode_nxt  = '0;
          pend_we_nxt    = '0;
          case (in_func)
            ristab_pkg::FUNC_ACQUIRE: begin
              ino_nxt       = ino_in;
              pidx_nxt      = '0;
              have_free_nxt = 1'b0;
              ram_rd_addr   = '0;
              state_nxt     = S_SCAN;
            end
            ristab_pkg::FUNC_RELEASE: begin
              idx_nxt = in_slot_index;
              if (32'(in_slot_index) < 32'(SLOTS)) begin
                ram_rd_addr = AW'(in_slot_index);
                state_nxt   = S_REL;
              end else begin
                res_status_nxt = ristab_pkg::ST_IDLE;
                res_slot_nxt   = in_slot_index;
                state_nxt      = S_DONE;
              end
            end
            ristab_pkg::FUNC_CLEAR: begin
              cnt_nxt     = '0;
              clr_rep_nxt = 1'b1;
              state_nxt   = S_INIT;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // data for slot pidx_r is on the read port; fetch the next slot
        ram_rd_addr = AW'(pidx_r + 1'b1);
        pidx_nxt    = AW'(pidx_r + 1'b1);
        if (hit) begin
          res_slot_nxt  = 6'(pidx_r);
          res_inode_nxt = 16'(ram_rd_tag);
          res_load_nxt  = 1'b0;
          pend_addr_nxt = pidx_r;
          pend_refs_nxt = ram_rd_refs + CW'(1);
          if (ram_rd_refs == COUNT_TOP) begin
            res_status_nxt = ristab_pkg::ST_SAT;
          end else begin
            res_status_nxt      = ristab_pkg::ST_OK;
            pend_we_nxt.refs_we = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          if (ram_rd_refs == '0 && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = pidx_r;
          end
          if (pidx_r == LAST) begin
            if (last_free) begin
              res_status_nxt = ristab_pkg::ST_OK;
              res_slot_nxt   = 6'(have_free_r ? free_r : pidx_r);
              res_load_nxt   = 1'b1;
              res_inode_nxt  = 16'(ino_r);
              pend_we_nxt    = '{refs_we: 1'b1, tag_we: 1'b1};
              pend_addr_nxt  = have_free_r ? free_r : pidx_r;
              pend_tag_nxt   = ino_r;
              pend_refs_nxt  = CW'(1);
            end else begin
              res_status_nxt = ristab_pkg::ST_FULL;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_REL: begin
        res_slot_nxt = idx_r;
        if (ram_rd_refs == '0) begin
          res_status_nxt = ristab_pkg::ST_IDLE;
        end else begin
          res_status_nxt      = ristab_pkg::ST_OK;
          res_wb_nxt          = (dec_refs == '0);
          res_inode_nxt       = 16'(ram_rd_tag);
          pend_we_nxt.refs_we = 1'b1;
          pend_addr_nxt       = AW'(idx_r);
          pend_refs_nxt       = dec_refs;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold the result and the table update until the output register frees
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_load_nxt   = res_load_r;
          out_wb_nxt     = res_wb_r;
          out_inode_nxt  = res_inode_r;
          ram_we         = pend_we_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      clr_rep_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pend_we_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_rep_r   <= clr_rep_nxt;
      out_valid_r <= out_valid_nxt;
      pend_we_r   <= pend_we_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    ino_r        <= ino_nxt;
    have_free_r  <= have_free_nxt;
    free_r       <= free_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_load_r   <= res_load_nxt;
    res_wb_r     <= res_wb_nxt;
    res_inode_r  <= res_inode_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_tag_r   <= pend_tag_nxt;
    pend_refs_r  <= pend_refs_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_load_r   <= out_load_nxt;
    out_wb_r     <= out_wb_nxt;
    out_inode_r  <= out_inode_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot_out         = out_slot_r;
  assign out_load_needed      = out_load_r;
  assign out_writeback_needed = out_wb_r;
  assign out_inode_out        = out_inode_r;

  // a fresh result is only ever loaded from the finishing state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the finishing state");

  // a tag write is always an allocation with count one
  a_tag_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we.tag_we |-> (ram_we.refs_we && ram_wr_refs == CW'(1)))
    else $error("tag written without allocation");

  // a load request never goes with a writeback or a failing status
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_load_r) |-> (out_status_r == ristab_pkg::ST_OK && !out_wb_r))
    else $error("load request with bad status");

  // no item is taken while the count sweep runs
  a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |=> ((state_r != S_SCAN) && (state_r != S_REL)))
    else $error("item started during count sweep");

endmodule : refcounted_inode_slot_table_unit
`default_nettype wire
